[hw/rtl/bounded_deque_macros.svh]
// Assertion macros shared by the deque checker.
`ifndef BOUNDED_DEQUE_MACROS_SVH
`define BOUNDED_DEQUE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BDQ_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("bounded_deque check failed");

// Check that a condition implies another one on the next clock edge.
`define BDQ_ASSERT_NEXT(label, clk, rst_n, cond, nxt) \
    `BDQ_ASSERT(label, clk, rst_n, (cond) |=> (nxt))

`endif

[hw/rtl/bdq_pkg.sv]
// Shared types, codes and ring helpers of the bounded deque.
`default_nettype none

package bdq_pkg;

    // Geometry; the result's entry count field is five bits wide
    localparam int DEPTH  = 16;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = 5;
    localparam int WORD_W = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    // Command codes; the unused codes act as read only
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ       = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [WORD_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [WORD_W-1:0] front_word;
        logic signed [WORD_W-1:0] back_word;
        logic [CNT_W-1:0]         entry_count;
        logic                     is_empty;
        logic [STAT_W-1:0]        status;
    } t_out_item;

    // Ring position head + offset, offset at most DEPTH: one compare and subtract
    function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] head,
                                                   input logic [CNT_W-1:0] offset);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - ADDR_W){1'b0}}, head} + {1'b0, offset};
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

[hw/rtl/bdq_ram.sv]
// Ring storage: one write port, two registered read ports.
`default_nettype none

module bdq_ram (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [bdq_pkg::ADDR_W-1:0]             i_waddr,
    input  wire logic signed [bdq_pkg::WORD_W-1:0]      i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [bdq_pkg::ADDR_W-1:0]             i_raddr_f,
    input  wire logic [bdq_pkg::ADDR_W-1:0]             i_raddr_b,
    output logic signed [bdq_pkg::WORD_W-1:0]           o_rdata_f,
    output logic signed [bdq_pkg::WORD_W-1:0]           o_rdata_b
);

    logic signed [bdq_pkg::WORD_W-1:0] r_mem [bdq_pkg::DEPTH];

    // Write the pushed word
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read both ends; hold the data while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_f <= r_mem[i_raddr_f];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/bdq_ctrl.sv]
// Deque control: pointer update, read sequencing and result register.
`default_nettype none

module bdq_ctrl (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_in_valid,
    input  wire bdq_pkg::t_in_item                      i_in_item,
    output logic                                        o_in_ready,
    output logic                                        o_out_valid,
    output bdq_pkg::t_out_item                          o_out_item,
    input  wire logic                                   i_out_ready,
    output logic                                        o_mem_we,
    output logic [bdq_pkg::ADDR_W-1:0]                  o_mem_waddr,
    output logic signed [bdq_pkg::WORD_W-1:0]           o_mem_wdata,
    output logic                                        o_mem_re,
    output logic [bdq_pkg::ADDR_W-1:0]                  o_mem_raddr_f,
    output logic [bdq_pkg::ADDR_W-1:0]                  o_mem_raddr_b,
    input  wire logic signed [bdq_pkg::WORD_W-1:0]      i_mem_rdata_f,
    input  wire logic signed [bdq_pkg::WORD_W-1:0]      i_mem_rdata_b
);

    bdq_pkg::t_state                  r_state, n_state;
    logic [bdq_pkg::ADDR_W-1:0]       r_head, n_head;
    logic [bdq_pkg::CNT_W-1:0]        r_count, n_count;
    logic [bdq_pkg::STAT_W-1:0]       r_status, n_status;
    logic                             r_out_valid, n_out_valid;
    bdq_pkg::t_out_item               r_out_item, n_out_item;
    logic                             in_acc;
    logic                             out_load;
    logic                             full;
    logic                             empty;

    assign in_acc = i_in_valid && o_in_ready;
    assign full   = (r_count == bdq_pkg::DEPTH_CNT);
    assign empty  = (r_count == '0);

    // Decode the command: new head, count, status and the store write
    always_comb begin
        n_head      = r_head;
        n_count     = r_count;
        n_status    = r_status;
        o_mem_we    = 1'b0;
        o_mem_waddr = bdq_pkg::ring_add(r_head, r_count);
        o_mem_wdata = i_in_item.value;
        if (in_acc) begin
            n_status = bdq_pkg::STAT_DONE;
            case (i_in_item.cmd)
                bdq_pkg::CMD_PUSH_FRONT: begin
                    if (full) begin
                        n_status = bdq_pkg::STAT_FULL;
                    end else begin
                        n_head      = bdq_pkg::ring_add(r_head,
                                          bdq_pkg::DEPTH_CNT - bdq_pkg::CNT_W'(1));
                        o_mem_waddr = n_head;
                        o_mem_we    = 1'b1;
                        n_count     = r_count + bdq_pkg::CNT_W'(1);
                    end
                end
                bdq_pkg::CMD_PUSH_BACK: begin
                    if (full) begin
                        n_status = bdq_pkg::STAT_FULL;
                    end else begin
                        o_mem_we = 1'b1;
                        n_count  = r_count + bdq_pkg::CNT_W'(1);
                    end
                end
                bdq_pkg::CMD_POP_FRONT: begin
                    if (empty) begin
                        n_status = bdq_pkg::STAT_EMPTY;
                    end else begin
                        n_head  = bdq_pkg::ring_add(r_head, bdq_pkg::CNT_W'(1));
                        n_count = r_count - bdq_pkg::CNT_W'(1);
                    end
                end
                bdq_pkg::CMD_POP_BACK: begin
                    if (empty) begin
                        n_status = bdq_pkg::STAT_EMPTY;
                    end else begin
                        n_count = r_count - bdq_pkg::CNT_W'(1);
                    end
                end
                default: begin
                    n_status = bdq_pkg::STAT_DONE;
                end
            endcase
        end
    end

    // Read addresses of both ends; the write of the accepted item lands before the read state
    always_comb begin
        o_mem_raddr_f = r_head;
        o_mem_raddr_b = empty ? r_head
                              : bdq_pkg::ring_add(r_head, r_count - bdq_pkg::CNT_W'(1));
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bdq_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = bdq_pkg::ST_READ;
                end
            end
            bdq_pkg::ST_READ: begin
                n_state = bdq_pkg::ST_LOAD;
            end
            bdq_pkg::ST_LOAD: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = bdq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bdq_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_mem_re   = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            bdq_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            bdq_pkg::ST_READ: begin
                o_mem_re = 1'b1;
            end
            bdq_pkg::ST_LOAD: begin
                out_load = !r_out_valid || i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Build the result; empty deque shows zero words
    always_comb begin
        n_out_item             = r_out_item;
        n_out_valid            = r_out_valid && !i_out_ready;
        if (out_load) begin
            n_out_valid            = 1'b1;
            n_out_item.front_word  = empty ? '0 : i_mem_rdata_f;
            n_out_item.back_word   = empty ? '0 : i_mem_rdata_b;
            n_out_item.entry_count = r_count;
            n_out_item.is_empty    = empty;
            n_out_item.status      = r_status;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bdq_pkg::ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_status    <= bdq_pkg::STAT_DONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_status    <= n_status;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

[hw/rtl/bounded_deque.sv]
// Top level of the bounded deque: control sequencer and ring storage.
//
//   channel   direction  handshake                    payload
//   in        in         i_in_valid / o_in_ready      i_in_item  (cmd, value)
//   out       out        o_out_valid / i_out_ready    o_out_item (front, back, count, flags)
//
// Each item passes three steps: accept and write the store, read both ends
// from the two read ports of the store, load the result register.
// The registered store read sets the separate read step; the next item is
// taken once the result register is loaded.
// A stalled result holds the sequencer in its load step; the read data stays put.
// Reset (synchronous, active low) clears state, head, count, status and valid, not the store.
`default_nettype none

module bounded_deque (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire bdq_pkg::t_in_item   i_in_item,
    output logic                     o_in_ready,
    output logic                     o_out_valid,
    output bdq_pkg::t_out_item       o_out_item,
    input  wire logic                i_out_ready
);

    logic                                 mem_we;
    logic [bdq_pkg::ADDR_W-1:0]           mem_waddr;
    logic signed [bdq_pkg::WORD_W-1:0]    mem_wdata;
    logic                                 mem_re;
    logic [bdq_pkg::ADDR_W-1:0]           mem_raddr_f;
    logic [bdq_pkg::ADDR_W-1:0]           mem_raddr_b;
    logic signed [bdq_pkg::WORD_W-1:0]    mem_rdata_f;
    logic signed [bdq_pkg::WORD_W-1:0]    mem_rdata_b;

    // Sequence commands and hold the result
    bdq_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_item     (i_in_item),
        .o_in_ready    (o_in_ready),
        .o_out_valid   (o_out_valid),
        .o_out_item    (o_out_item),
        .i_out_ready   (i_out_ready),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_re      (mem_re),
        .o_mem_raddr_f (mem_raddr_f),
        .o_mem_raddr_b (mem_raddr_b),
        .i_mem_rdata_f (mem_rdata_f),
        .i_mem_rdata_b (mem_rdata_b)
    );

    // Store the ring entries
    bdq_ram u_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_re      (mem_re),
        .i_raddr_f (mem_raddr_f),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_f (mem_rdata_f),
        .o_rdata_b (mem_rdata_b)
    );

endmodule

`default_nettype wire

[hw/rtl/bdq_checker.sv]
// Port-level checks of the bounded deque, bound to the top level.
`default_nettype none

`include "bounded_deque_macros.svh"

module bdq_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire bdq_pkg::t_in_item   i_in_item,
    input wire logic                o_in_ready,
    input wire logic                o_out_valid,
    input wire bdq_pkg::t_out_item  o_out_item,
    input wire logic                i_out_ready
);

    logic out_stall;
    logic in_wait;
    logic count_zero;
    logic count_full;
    logic words_zero;
    logic stat_full;

    // Decode the port conditions used below
    assign out_stall  = o_out_valid && !i_out_ready;
    assign in_wait    = i_in_valid && !o_in_ready;
    assign count_zero = (o_out_item.entry_count == '0);
    assign count_full = (o_out_item.entry_count == bdq_pkg::DEPTH_CNT);
    assign words_zero = (o_out_item.front_word == '0) && (o_out_item.back_word == '0);
    assign stat_full  = (o_out_item.status == bdq_pkg::STAT_FULL);

    // A result that is not taken stays, unchanged
    `BDQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_out_item))

    // An offered item that is not taken stays, unchanged
    `BDQ_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, in_wait, i_in_valid && $stable(i_in_item))

    // Empty flag agrees with the count
    `BDQ_ASSERT(a_empty_flag, i_clk, i_rst_n, o_out_valid |-> (o_out_item.is_empty == count_zero))

    // Empty deque shows zero words at both ends
    `BDQ_ASSERT(a_empty_zero, i_clk, i_rst_n, (o_out_valid && o_out_item.is_empty) |-> words_zero)

    // A push dropped for lack of room reports a full deque
    `BDQ_ASSERT(a_full_count, i_clk, i_rst_n, (o_out_valid && stat_full) |-> count_full)

endmodule

bind bounded_deque bdq_checker u_bdq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_item   (i_in_item),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item),
    .i_out_ready (i_out_ready)
);

`default_nettype wire
